### hw/rtl/sbc_pkg.sv
package sbc_pkg;

  // widths of the arithmetic path
  localparam int unsigned CRD_W    = 32;
  localparam int unsigned RAD_IN_W = 31;
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned REM_W    = 35;
  localparam int unsigned NUM_W    = 47;
  localparam int unsigned DEN_W    = 33;
  localparam int unsigned QBITS    = 15;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned DIR_ONE  = 16384;

  // item data riding alongside the arithmetic
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [RAD_IN_W-1:0] radius;
    logic [RAD_IN_W-1:0] mag_x;
    logic [RAD_IN_W-1:0] mag_y;
    logic [RAD_IN_W-1:0] mag_z;
    logic                neg_x;
    logic                neg_y;
    logic                neg_z;
  } sbc_side_t;

  // square root cell state
  typedef struct packed {
    sbc_side_t         side;
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sbc_sq_t;

  // division cell state, three lanes sharing one divisor
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                qzero;
    logic [RAD_IN_W-1:0] depth;
    logic                neg_x;
    logic                neg_y;
    logic                neg_z;
    logic [DEN_W-1:0]    den;
    logic [NUM_W-1:0]    num_x;
    logic [NUM_W-1:0]    num_y;
    logic [NUM_W-1:0]    num_z;
    logic [QBITS-1:0]    quo_x;
    logic [QBITS-1:0]    quo_y;
    logic [QBITS-1:0]    quo_z;
  } sbc_dv_t;

endpackage

### hw/rtl/sbc_sqrt_cell.sv
module sbc_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  sbc_pkg::sbc_sq_t d_in,
  output sbc_pkg::sbc_sq_t d_out
);

  sbc_pkg::sbc_sq_t               d_r;
  sbc_pkg::sbc_sq_t               d_nxt;
  logic [sbc_pkg::REM_W-1:0]      rem_sh;
  logic [sbc_pkg::REM_W-1:0]      trial;

  // one root bit per cell
  always_comb begin
    rem_sh = {d_in.rem[sbc_pkg::REM_W-3:0], d_in.rad[sbc_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, d_in.root, 2'b01};
    d_nxt      = d_in;
    d_nxt.rad  = {d_in.rad[sbc_pkg::SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = rem_sh - trial;
      d_nxt.root = {d_in.root[sbc_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh;
      d_nxt.root = {d_in.root[sbc_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) begin
      d_r.side.valid <= 1'b0;
    end
  end

  assign d_out = d_r;

endmodule

### hw/rtl/sbc_div_cell.sv
module sbc_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sbc_pkg::sbc_dv_t d_in,
  output sbc_pkg::sbc_dv_t d_out
);

  sbc_pkg::sbc_dv_t           d_r;
  sbc_pkg::sbc_dv_t           d_nxt;
  logic [sbc_pkg::NUM_W-1:0]  cmp;
  logic                       bx;
  logic                       by;
  logic                       bz;

  // one quotient bit per cell on all three lanes
  always_comb begin
    cmp = sbc_pkg::NUM_W'(d_in.den) << SHIFT;
    bx  = (d_in.num_x >= cmp);
    by  = (d_in.num_y >= cmp);
    bz  = (d_in.num_z >= cmp);
    d_nxt       = d_in;
    d_nxt.num_x = bx ? d_in.num_x - cmp : d_in.num_x;
    d_nxt.num_y = by ? d_in.num_y - cmp : d_in.num_y;
    d_nxt.num_z = bz ? d_in.num_z - cmp : d_in.num_z;
    d_nxt.quo_x = {d_in.quo_x[sbc_pkg::QBITS-2:0], bx};
    d_nxt.quo_y = {d_in.quo_y[sbc_pkg::QBITS-2:0], by};
    d_nxt.quo_z = {d_in.quo_z[sbc_pkg::QBITS-2:0], bz};
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end
  end

  assign d_out = d_r;

endmodule

### hw/rtl/sphere_box_collision.sv
// Sphere against axis-aligned box test, fully pipelined: one item may be
// started in every clock cycle and busy is always low. Each item gives one
// result on out_valid after it is taken, passing through the clamp, square
// and sum registers, a chain of 32 square root cells (one root
// bit each), a rounding register, a chain of 15 division cells (one direction
// bit each, all three axes in parallel) and the output register. The
// receiver cannot stall, so results must be taken when the strobe shows.
module sphere_box_collision (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic [30:0] in_sphere_radius,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  output logic        out_valid,
  output logic        out_hit,
  output logic [30:0] out_depth,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z
);

  localparam int unsigned SQ_CELLS = sbc_pkg::ROOT_W;
  localparam int unsigned DV_CELLS = sbc_pkg::QBITS;

  logic              take;
  // stage 1: clamped offsets
  logic [2:0][32:0]  dd;
  logic [2:0][32:0]  mg;
  logic              big;
  sbc_pkg::sbc_side_t s1_r;
  sbc_pkg::sbc_side_t s1_nxt;
  logic              s1_miss_r;
  // stage 2: squares
  sbc_pkg::sbc_side_t s2_r;
  logic              s2_miss_r;
  logic [61:0]       sqx_r;
  logic [61:0]       sqy_r;
  logic [61:0]       sqz_r;
  logic [61:0]       r2_r;
  // stage 3: sum and compare
  sbc_pkg::sbc_sq_t  s3_r;
  sbc_pkg::sbc_sq_t  s3_nxt;
  logic [sbc_pkg::SQ_W-1:0] sum;
  // chains
  sbc_pkg::sbc_sq_t  sq_chain [SQ_CELLS+1];
  sbc_pkg::sbc_dv_t  dv_chain [DV_CELLS+1];
  sbc_pkg::sbc_dv_t  rd_r;
  sbc_pkg::sbc_dv_t  rd_nxt;
  sbc_pkg::sbc_sq_t  sq_end;
  logic [sbc_pkg::ROOT_W-1:0] q;
  sbc_pkg::sbc_dv_t  dv_end;
  logic              show;

  assign take = start && !busy;
  assign busy = 1'b0;

  // clamp each axis into the box slab
  always_comb begin
    logic signed [32:0] c [3];
    logic signed [32:0] lo [3];
    logic signed [32:0] hi [3];
    logic signed [32:0] p;
    c[0]  = 33'(in_center_x);  c[1]  = 33'(in_center_y);  c[2]  = 33'(in_center_z);
    lo[0] = 33'(in_box_min_x); lo[1] = 33'(in_box_min_y); lo[2] = 33'(in_box_min_z);
    hi[0] = 33'(in_box_max_x); hi[1] = 33'(in_box_max_y); hi[2] = 33'(in_box_max_z);
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (c[i] < lo[i]) begin
        p = lo[i];
      end else if (c[i] > hi[i]) begin
        p = hi[i];
      end else begin
        p = c[i];
      end
      dd[i] = c[i] - p;
      mg[i] = dd[i][32] ? -dd[i] : dd[i];
      if (mg[i][32:31] != 2'b00) begin
        big = 1'b1;
      end
    end
    s1_nxt.valid  = take;
    s1_nxt.hit    = 1'b0;
    s1_nxt.radius = in_sphere_radius;
    s1_nxt.mag_x  = mg[0][30:0];
    s1_nxt.mag_y  = mg[1][30:0];
    s1_nxt.mag_z  = mg[2][30:0];
    s1_nxt.neg_x  = dd[0][32];
    s1_nxt.neg_y  = dd[1][32];
    s1_nxt.neg_z  = dd[2][32];
  end

  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s1_miss_r <= big;
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end
  end

  // squares of offsets and radius
  always_ff @(posedge clk) begin
    s2_r      <= s1_r;
    s2_miss_r <= s1_miss_r;
    sqx_r     <= 62'(s1_r.mag_x) * 62'(s1_r.mag_x);
    sqy_r     <= 62'(s1_r.mag_y) * 62'(s1_r.mag_y);
    sqz_r     <= 62'(s1_r.mag_z) * 62'(s1_r.mag_z);
    r2_r      <= 62'(s1_r.radius) * 62'(s1_r.radius);
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end
  end

  // exact sum, compare with radius squared
  always_comb begin
    sum = sbc_pkg::SQ_W'(sqx_r) + sbc_pkg::SQ_W'(sqy_r) + sbc_pkg::SQ_W'(sqz_r);
    s3_nxt          = '0;
    s3_nxt.side     = s2_r;
    s3_nxt.side.hit = !s2_miss_r && (sum <= sbc_pkg::SQ_W'(r2_r));
    s3_nxt.rad      = sum;
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
    if (!rst_n) begin
      s3_r.side.valid <= 1'b0;
    end
  end

  // square root chain
  assign sq_chain[0] = s3_r;
  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    sbc_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_chain[g]),
      .d_out (sq_chain[g+1])
    );
  end

  // round root to nearest, set up the division lanes
  always_comb begin
    sq_end = sq_chain[SQ_CELLS];
    q = (sq_end.rem > sbc_pkg::REM_W'(sq_end.root)) ? sq_end.root + 1'b1 : sq_end.root;
    rd_nxt       = '0;
    rd_nxt.valid = sq_end.side.valid;
    rd_nxt.hit   = sq_end.side.hit;
    rd_nxt.qzero = (q == '0);
    rd_nxt.depth = sq_end.side.radius - q[sbc_pkg::RAD_IN_W-1:0];
    rd_nxt.neg_x = sq_end.side.neg_x;
    rd_nxt.neg_y = sq_end.side.neg_y;
    rd_nxt.neg_z = sq_end.side.neg_z;
    rd_nxt.den   = {q, 1'b0};
    rd_nxt.num_x = {1'b0, sq_end.side.mag_x, 15'b0} + sbc_pkg::NUM_W'(q);
    rd_nxt.num_y = {1'b0, sq_end.side.mag_y, 15'b0} + sbc_pkg::NUM_W'(q);
    rd_nxt.num_z = {1'b0, sq_end.side.mag_z, 15'b0} + sbc_pkg::NUM_W'(q);
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    if (!rst_n) begin
      rd_r.valid <= 1'b0;
    end
  end

  // division chain, most significant quotient bit first
  assign dv_chain[0] = rd_r;
  for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
    sbc_div_cell #(.SHIFT(DV_CELLS - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (dv_chain[g]),
      .d_out (dv_chain[g+1])
    );
  end

  // result register
  assign dv_end = dv_chain[DV_CELLS];
  assign show   = dv_end.hit && !dv_end.qzero;

  always_ff @(posedge clk) begin
    out_hit   <= dv_end.hit;
    out_depth <= dv_end.hit ? dv_end.depth : '0;
    out_dir_x <= !show ? '0 : dv_end.neg_x ? -{1'b0, dv_end.quo_x} : {1'b0, dv_end.quo_x};
    out_dir_y <= !show ? '0 : dv_end.neg_y ? -{1'b0, dv_end.quo_y} : {1'b0, dv_end.quo_y};
    out_dir_z <= !show ? '0 : dv_end.neg_z ? -{1'b0, dv_end.quo_z} : {1'b0, dv_end.quo_z};
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_end.valid;
    end
  end

  // checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_depth == '0 && out_dir_x == '0 && out_dir_y == '0
      && out_dir_z == '0)
    else $error("miss with non-zero payload");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_x <= 16'sd16384 && out_dir_x >= -16'sd16384
      && out_dir_y <= 16'sd16384 && out_dir_y >= -16'sd16384)
    else $error("direction out of range");

  a_round_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r.valid |=> dv_chain[1].valid)
    else $error("item lost in division chain");

endmodule

### verif/sbc_checker.sv
`timescale 1ns / 1ps

module sbc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic [30:0]        in_sphere_radius,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  input  logic               out_valid,
  input  logic               out_hit,
  input  logic [30:0]        out_depth,
  input  logic signed [15:0] out_dir_x,
  input  logic signed [15:0] out_dir_y,
  input  logic signed [15:0] out_dir_z,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic        hit;
    logic [30:0] depth;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
  } contact_t;

  contact_t contact_q[$];

  // integer square root, bit by bit
  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // closest box point, depth and push direction for one query
  function automatic contact_t sphere_contact(logic signed [31:0] c[3],
                                              logic signed [31:0] lo[3],
                                              logic signed [31:0] hi[3],
                                              logic [30:0] rad);
    contact_t res;
    longint off[3];
    longint unsigned mag[3];
    longint unsigned r2;
    longint unsigned sum;
    longint unsigned q;
    longint unsigned v;
    logic far_off;
    logic [15:0] comp[3];
    res = '0;
    far_off = 1'b0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (c[i] < lo[i]) off[i] = longint'(c[i]) - longint'(lo[i]);
      else if (c[i] > hi[i]) off[i] = longint'(c[i]) - longint'(hi[i]);
      else off[i] = 0;
      mag[i] = (off[i] < 0) ? -off[i] : off[i];
      if (mag[i] >= 64'h8000_0000) far_off = 1'b1;
      comp[i] = '0;
    end
    if (far_off) return res;
    r2 = longint'(rad) * longint'(rad);
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    if (sum > r2) return res;
    q = isqrt(sum);
    if (sum - q * q > q) q++;
    res.hit = 1'b1;
    res.depth = rad - q[30:0];
    if (q != 0) begin
      for (int i = 0; i < 3; i++) begin
        v = (mag[i] * 32768 + q) / (2 * q);
        comp[i] = (off[i] < 0) ? -v[15:0] : v[15:0];
      end
    end
    res.dir_x = comp[0];
    res.dir_y = comp[1];
    res.dir_z = comp[2];
    return res;
  endfunction

  assign pending = contact_q.size();

  // predict on accept, compare on strobe
  always @(posedge clk) begin
    contact_t exp_c;
    contact_t got;
    logic signed [31:0] c[3];
    logic signed [31:0] lo[3];
    logic signed [31:0] hi[3];
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        got = {out_hit, out_depth, out_dir_x, out_dir_y, out_dir_z};
        if (contact_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_c = contact_q.pop_front();
          if (got !== exp_c) begin
            if (fail_count < 10)
              $display("mismatch: hit %b/%b depth %h/%h dir %h %h %h / %h %h %h",
                       exp_c.hit, got.hit, exp_c.depth, got.depth,
                       exp_c.dir_x, exp_c.dir_y, exp_c.dir_z,
                       got.dir_x, got.dir_y, got.dir_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        c  = '{in_center_x, in_center_y, in_center_z};
        lo = '{in_box_min_x, in_box_min_y, in_box_min_z};
        hi = '{in_box_max_x, in_box_max_y, in_box_max_z};
        contact_q.push_back(sphere_contact(c, lo, hi, in_sphere_radius));
      end
    end
  end

endmodule

### verif/tb_sphere_box_collision.sv
`timescale 1ns / 1ps

module tb_sphere_box_collision;

  localparam int LATENCY = 52;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [30:0] in_sphere_radius = '0;
  logic signed [31:0] in_box_min_x = '0, in_box_min_y = '0, in_box_min_z = '0;
  logic signed [31:0] in_box_max_x = '0, in_box_max_y = '0, in_box_max_z = '0;
  logic out_valid, out_hit;
  logic [30:0] out_depth;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  int fail_count;
  int pending;
  int idle_pct;
  int quiet_cycles;

  always #5 clk = ~clk;

  sphere_box_collision DUT (.*);
  sbc_checker u_checker (.*);

  // watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_crd(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
      default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
    endcase
  endfunction

  // present one item and hold until taken
  task automatic send_query(logic signed [31:0] c[3], logic [30:0] rad,
                            logic signed [31:0] lo[3], logic signed [31:0] hi[3]);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_center_x <= c[0]; in_center_y <= c[1]; in_center_z <= c[2];
    in_sphere_radius <= rad;
    in_box_min_x <= lo[0]; in_box_min_y <= lo[1]; in_box_min_z <= lo[2];
    in_box_max_x <= hi[0]; in_box_max_y <= hi[1]; in_box_max_z <= hi[2];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random query, mostly near the box so hits are common
  task automatic random_query();
    logic signed [31:0] c[3], lo[3], hi[3];
    logic [30:0] rad;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    for (int i = 0; i < 3; i++) begin
      lo[i] = rnd_crd(mode);
      hi[i] = $urandom_range(0, 9) == 0 ? rnd_crd(mode) : lo[i] + $urandom_range(0, 5000);
      c[i] = rnd_crd(mode);
    end
    case ($urandom_range(0, 3))
      0: rad = 31'($urandom());
      1: rad = 31'($urandom_range(0, 32'h4_0000));
      default: rad = 31'($urandom_range(0, 3000));
    endcase
    send_query(c, rad, lo, hi);
  endtask

  initial begin
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: inside, on face, corner, extremes, inverted box, zero radius
    send_query('{0, 0, 0}, 31'd5, '{-10, -10, -10}, '{10, 10, 10});
    send_query('{10, 0, 0}, 31'd0, '{-10, -10, -10}, '{10, 10, 10});
    send_query('{13, 4, 0}, 31'd5, '{-10, -10, -10}, '{10, 0, 10});
    send_query('{13, 14, 10}, 31'd5, '{-10, -10, -10}, '{10, 10, 10});
    send_query('{-13, -14, -22}, 31'd20, '{-10, -10, -10}, '{10, 10, 10});
    send_query('{0, 0, 16}, 31'd5, '{-10, -10, -10}, '{10, 10, 10});
    send_query('{32'sh7fffffff, 0, 0}, 31'h7fffffff, '{32'sh80000000, 0, 0}, '{32'sh80000000, 0, 0});
    send_query('{32'sh80000000, 32'sh80000000, 32'sh80000000}, 31'h7fffffff,
               '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, '{0, 0, 0});
    send_query('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 31'h7fffffff,
               '{0, 0, 0}, '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_query('{32'sh7ffffffe, 0, 0}, 31'h7fffffff, '{32'sh80000000, 0, 0}, '{32'shffffffff, 0, 0});
    send_query('{5, 5, 5}, 31'd100, '{10, 10, 10}, '{-10, -10, -10});
    send_query('{20, 0, 0}, 31'd100, '{10, -5, -5}, '{-10, 5, 5});
    send_query('{30000, 40000, 0}, 31'd50000, '{0, 0, 0}, '{0, 0, 0});
    send_query('{1, 1, 1}, 31'd2, '{0, 0, 0}, '{0, 0, 0});
    send_query('{-3, 4, 0}, 31'd5, '{0, 0, 0}, '{0, 0, 0});

    // random phases with varied sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : (ph == 2) ? 19 : 0;
      for (int n = 0; n < 150; n++) random_query();
      start <= 1'b0;
      if (ph == 1) begin
        // hold off until the pipeline drains
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 20 * LATENCY && pending != 0; n++) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
